[hw/rtl/bounded_sorted_key_table_assert.svh]
// Assertion macros for the module that carries checks.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef BOUNDED_SORTED_KEY_TABLE_ASSERT_SVH
`define BOUNDED_SORTED_KEY_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Expression must hold at every clock edge out of reset.
`define BSKT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[hw/rtl/bskt_pkg.sv]
`timescale 1ns / 1ps

package bskt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_CAPACITY_LIMIT = 0;
    localparam logic [3:0] CAP_LIMIT_RESET = 4'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] key;
        logic [15:0] name_id;
        logic [7:0]  room_id;
        logic [7:0]  slot_id;
        logic [2:0]  day_index;
    } bskt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_key;
        logic [15:0] found_name_id;
        logic [7:0]  found_room_id;
        logic [7:0]  found_slot_id;
        logic [2:0]  found_day;
        logic [3:0]  entry_count;
    } bskt_out_t;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] name_id;
        logic [7:0]  room_id;
        logic [7:0]  slot_id;
        logic [2:0]  day;
    } bskt_record_t;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } bskt_rd_sel_t;

    typedef struct packed {
        logic         load_req;
        logic         rd_en;
        bskt_rd_sel_t rd_sel;
        logic         wr_rdata;
        logic         wr_new;
        logic         idx_inc;
        logic         idx_dec;
        logic         set_shift;
        logic         cnt_dec;
        logic         set_status;
        logic [1:0]   status_code;
        logic         capture_found;
        logic         out_load;
    } bskt_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       idx_at_end;
        logic       idx_zero;
        logic       idx_at_pos;
        logic       last_entry;
        logic       key_eq;
        logic       key_lt;
        logic       key_gt;
    } bskt_sts_t;

endpackage

[hw/rtl/bskt_chan_if.sv]
`timescale 1ns / 1ps

interface bskt_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/bskt_ctrl.sv]
`timescale 1ns / 1ps

module bskt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bskt_pkg::bskt_sts_t sts,
    output bskt_pkg::bskt_cmd_t cmd
);
    import bskt_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_START     = 11'b000_0000_0010,
        S_INS_RD    = 11'b000_0000_0100,
        S_INS_CMP   = 11'b000_0000_1000,
        S_INS_SH_RD = 11'b000_0001_0000,
        S_INS_SH_WR = 11'b000_0010_0000,
        S_INS_WR    = 11'b000_0100_0000,
        S_FIND_RD   = 11'b000_1000_0000,
        S_FIND_CMP  = 11'b001_0000_0000,
        S_DEL_RD    = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    OP_SEARCH, OP_DELETE:
                    begin
                        state_next = S_FIND_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (sts.idx_at_end)
                begin
                    cmd.set_shift = 1'b1;
                    state_next    = S_INS_SH_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                // The head is only tested for strictly greater; later entries
                // are passed while their key is less than the new one.
                if (sts.idx_zero ? sts.key_gt : !sts.key_lt)
                begin
                    cmd.set_shift = 1'b1;
                    state_next    = S_INS_SH_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_INS_RD;
                end
            end
            S_INS_SH_RD:
            begin
                if (sts.idx_at_pos)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_SH_WR;
                end
            end
            S_INS_SH_WR:
            begin
                // Insert moves entries up and walks down; delete moves them
                // down and walks up.
                cmd.wr_rdata = 1'b1;
                if (sts.op == OP_DELETE)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DEL_RD;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_SH_RD;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_DONE;
            end
            S_FIND_RD:
            begin
                if (sts.idx_at_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP:
            begin
                if (!sts.key_eq)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND_RD;
                end
                else if (sts.op == OP_SEARCH)
                begin
                    cmd.capture_found = 1'b1;
                    state_next        = S_DONE;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_RD:
            begin
                // Delete pulls each later entry down by one: it is read here and
                // written one place lower in the next cycle.
                if (sts.last_entry)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_INS_SH_WR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/bskt_datapath.sv]
`timescale 1ns / 1ps

module bskt_datapath #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bskt_pkg::bskt_in_t  in_data,
    input  logic [3:0]          capacity_limit,
    input  bskt_pkg::bskt_cmd_t cmd,
    output bskt_pkg::bskt_sts_t sts,
    output bskt_pkg::bskt_out_t out_data
);
    import bskt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    bskt_record_t entry_mem [TABLE_DEPTH];
    bskt_record_t rd_data_reg;

    bskt_in_t     req_reg, req_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [1:0]   status_reg, status_next;
    bskt_record_t found_reg, found_next;
    bskt_out_t    out_reg, out_next;

    logic [CW-1:0] rd_addr_w;
    logic [CW-1:0] idx_plus;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    bskt_record_t  wr_data;
    bskt_record_t  new_rec;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] limit_x;

    assign new_rec = '{key:     req_reg.key,
                       name_id: req_reg.name_id,
                       room_id: req_reg.room_id,
                       slot_id: req_reg.slot_id,
                       day:     req_reg.day_index};

    assign idx_plus = idx_reg + CW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr_w = idx_reg;
            RD_PREV: rd_addr_w = idx_reg - CW'(1);
            RD_NEXT: rd_addr_w = idx_plus;
            default: rd_addr_w = idx_reg;
        endcase
    end

    assign rd_addr = rd_addr_w[AW-1:0];
    assign wr_addr = idx_reg[AW-1:0];
    assign wr_data = cmd.wr_new ? new_rec : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_rdata || cmd.wr_new)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign cnt_x   = XW'(cnt_reg);
    assign limit_x = XW'(capacity_limit);

    always_comb
    begin
        sts.op         = req_reg.operation;
        sts.full       = (cnt_x >= limit_x) || (cnt_reg >= CW'(TABLE_DEPTH));
        sts.idx_at_end = (idx_reg >= cnt_reg);
        sts.idx_zero   = (idx_reg == '0);
        sts.idx_at_pos = (idx_reg == pos_reg);
        sts.last_entry = (idx_plus >= cnt_reg);
        sts.key_eq     = (rd_data_reg.key == req_reg.key);
        sts.key_lt     = (rd_data_reg.key < req_reg.key);
        sts.key_gt     = (rd_data_reg.key > req_reg.key);
    end

    always_comb
    begin
        req_next    = cmd.load_req ? in_data : req_reg;

        idx_next = idx_reg;
        if (cmd.load_req)
        begin
            idx_next = '0;
        end
        else if (cmd.set_shift)
        begin
            idx_next = cnt_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end

        pos_next = cmd.set_shift ? idx_reg : pos_reg;

        cnt_next = cnt_reg;
        if (cmd.wr_new)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end

        status_next = status_reg;
        if (cmd.load_req)
        begin
            status_next = ST_DONE;
        end
        else if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end

        found_next = found_reg;
        if (cmd.load_req)
        begin
            found_next = '0;
        end
        else if (cmd.capture_found)
        begin
            found_next = rd_data_reg;
        end

        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.status        = status_reg;
            out_next.found_key     = found_reg.key;
            out_next.found_name_id = found_reg.name_id;
            out_next.found_room_id = found_reg.room_id;
            out_next.found_slot_id = found_reg.slot_id;
            out_next.found_day     = found_reg.day;
            out_next.entry_count   = cnt_x[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        out_reg    <= out_next;
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/bounded_sorted_key_table.sv]
`timescale 1ns / 1ps
// Sorted record table with insert, search and delete requests.
// Requests arrive on in_ch (operation, key and record identifiers) and each one
// produces exactly one response on out_ch with a status, the found record on a
// successful search (zeros otherwise) and the entry count after the request.
// One request is worked at a time. The entry memory has a single read port, so
// every compare or move of an entry is split into a read state and a use state.
// Operation code 3 and an insert into a full table go straight to the response;
// an insert scans to its place and then moves the later entries up, a delete
// finds its match and then moves the later entries down.
// A finished response sits in an output register, so a new request is accepted
// while the previous response still waits; if out_ch stalls, the next response
// is held back in its final state until the register frees up.
// capacity_limit is written over APB at byte address 0 and resets to 5; write it
// only while no request is in flight. Reset empties the table at once; stored
// entries themselves are not cleared, since only held entries are ever read.
module bounded_sorted_key_table #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bskt_chan_if.sink                         in_ch,
    bskt_chan_if.source                       out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bskt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bskt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bskt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bskt_pkg::*;

    `include "bounded_sorted_key_table_assert.svh"

    logic [3:0] capacity_limit_reg, capacity_limit_next;
    logic       cfg_write;
    logic       reg_hit;
    bskt_cmd_t  cmd;
    bskt_sts_t  sts;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_CAPACITY_LIMIT));
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? {{(APB_DATA_W-4){1'b0}}, capacity_limit_reg} : '0;

    assign capacity_limit_next = (cfg_write && reg_hit) ? pwdata[3:0] : capacity_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_limit_reg <= CAP_LIMIT_RESET;
        end
        else
        begin
            capacity_limit_reg <= capacity_limit_next;
        end
    end

    bskt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bskt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_ch.data),
        .capacity_limit (capacity_limit_reg),
        .cmd            (cmd),
        .sts            (sts),
        .out_data       (out_ch.data)
    );

    // The table is only touched while a request is being worked.
    `BSKT_ASSERT_NOW(a_no_write_idle, in_ch.ready, !cmd.wr_rdata && !cmd.wr_new, "entry write while idle")
    // The single memory port never reads and writes in the same cycle.
    `BSKT_ASSERT_ALWAYS(a_one_mem_op, $onehot0({cmd.rd_en, cmd.wr_rdata, cmd.wr_new}), "memory port conflict")
    // An accepted request blocks the input until its response is registered.
    `BSKT_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken")
    // A response never overwrites one that has not been taken.
    `BSKT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_ch.valid || out_ch.ready, "response overwritten")

endmodule
